[rtl/core/assert_macros.svh]
// Assertion macros used by the top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |-> (post), msg)

`endif

[rtl/core/i2cra_pkg.sv]
// Package: types and constants of the I2C register access master.
`default_nettype none

package i2cra_pkg;

    // Kind codes of an incoming transfer.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       data_valid;
        logic [7:0] read_data;
        logic       last_data;
        logic       done_res;
        logic       ack_ok;
        logic       busy_res;
    } out_item_t;

    // Classified operation handed from the front to the engine.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] byte_count;
        logic       sda_in;
    } cmd_t;

    // Queue handshake between front and engine.
    typedef struct packed {
        logic push;
        logic full;
    } q_wr_ctl_t;

    typedef struct packed {
        logic pop;
        logic valid;
    } q_rd_ctl_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_TX_DEVW,
        PH_AK_DEVW,
        PH_TX_REG,
        PH_AK_REG,
        PH_TX_DATA,
        PH_AK_DATA,
        PH_RESTART,
        PH_TX_DEVR,
        PH_AK_DEVR,
        PH_RX,
        PH_RX_ACK,
        PH_STOP
    } phase_t;

endpackage

`default_nettype wire

[rtl/core/i2cra_front.sv]
// Front: accepts input transfers, classifies them and pushes them into the queue.
`default_nettype none

module i2cra_front (
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire i2cra_pkg::in_item_t cmd,
    input  wire logic                q_full,
    output i2cra_pkg::q_wr_ctl_t     q_wr,
    output i2cra_pkg::cmd_t          q_cmd
);
    import i2cra_pkg::*;

    assign cmd_ready  = !q_full;
    assign q_wr.push  = cmd_valid && !q_full;
    assign q_wr.full  = q_full;

    always_comb
    begin
        q_cmd.dev_addr   = cmd.dev_addr;
        q_cmd.reg_addr   = cmd.reg_addr;
        q_cmd.write_data = cmd.write_data;
        q_cmd.sda_in     = cmd.sda_in;
        q_cmd.byte_count = 8'd0;
        unique case (cmd.kind)
            KIND_TICK:  q_cmd.op = OP_TICK;
            KIND_WRITE: q_cmd.op = OP_WRITE;
            KIND_READ:
            begin
                q_cmd.op = OP_READ;
                // treat an empty burst as one byte
                q_cmd.byte_count = (cmd.read_count == 8'd0) ? 8'd1 : cmd.read_count;
            end
            default:    q_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/i2cra_queue.sv]
// Queue: short register FIFO between the front and the engine.
`default_nettype none

module i2cra_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2cra_pkg::q_wr_ctl_t wr,
    input  wire i2cra_pkg::cmd_t      wr_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output i2cra_pkg::q_rd_ctl_t      rd,
    output i2cra_pkg::cmd_t           rd_cmd
);
    import i2cra_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd.valid  = (count_reg != '0);
    assign do_pop    = pop && rd.valid;
    assign rd.pop    = do_pop;
    assign rd_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2cra_back.sv]
// Back: I2C bit engine that turns queued operations into pin drives and results.
`default_nettype none

module i2cra_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2cra_pkg::q_rd_ctl_t q_rd,
    input  wire i2cra_pkg::cmd_t      q_cmd,
    output logic                      q_pop,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output i2cra_pkg::out_item_t      rsp
);
    import i2cra_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] step_reg, step_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] left_reg, left_next;
    logic       ack_reg, ack_next;
    logic [6:0] dev_reg, dev_next;
    logic [7:0] regad_reg, regad_next;
    logic [7:0] wbyte_reg, wbyte_next;
    logic       rmode_reg, rmode_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    out_item_t  res;
    logic       take;
    logic       bitv;
    logic       ackdrv;
    logic [7:0] rx_byte;
    logic [7:0] left_dec;

    // Take a queued operation whenever the output slot is free or being drained.
    assign take      = q_rd.valid && (!out_valid_reg || rsp_ready);
    assign q_pop     = take;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign bitv     = shift_reg[bit_reg];
    assign ackdrv   = (left_reg > 8'd1);
    assign rx_byte  = shift_reg | {7'd0, q_cmd.sda_in};
    assign left_dec = (left_reg > 8'd0) ? left_reg - 8'd1 : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        ack_next   = ack_reg;
        dev_next   = dev_reg;
        regad_next = regad_reg;
        wbyte_next = wbyte_reg;
        rmode_next = rmode_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        res        = '0;

        if (q_cmd.op == OP_TICK)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                PH_START:
                begin
                    if (step_reg == 2'd0)
                    begin
                        scl_next = 1'b0; sda_next = 1'b0; step_next = 2'd1;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; step_next = 2'd2;
                    end
                    else
                    begin
                        scl_next   = 1'b1; sda_next = 1'b1;
                        phase_next = PH_TX_DEVW;
                        shift_next = {dev_reg, 1'b0};
                        bit_next   = 3'd7;
                        step_next  = 2'd0;
                    end
                end
                PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR:
                begin
                    sda_next = !bitv;
                    if (step_reg == 2'd0)
                    begin
                        scl_next  = 1'b1;
                        step_next = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        step_next = 2'd0;
                        if (bit_reg == 3'd0)
                        begin
                            unique case (phase_reg)
                                PH_TX_DEVW: phase_next = PH_AK_DEVW;
                                PH_TX_REG:  phase_next = PH_AK_REG;
                                PH_TX_DATA: phase_next = PH_AK_DATA;
                                default:    phase_next = PH_AK_DEVR;
                            endcase
                        end
                        else
                        begin
                            bit_next = bit_reg - 3'd1;
                        end
                    end
                end
                PH_AK_DEVW, PH_AK_REG, PH_AK_DATA, PH_AK_DEVR:
                begin
                    sda_next = 1'b0;
                    if (step_reg == 2'd0)
                    begin
                        scl_next = 1'b1; step_next = 2'd1;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        scl_next = 1'b0; step_next = 2'd2;
                    end
                    else
                    begin
                        scl_next = 1'b1;
                        // a released SDA at the sample point is a NACK
                        if (q_cmd.sda_in)
                        begin
                            ack_next = 1'b0;
                        end
                        bit_next  = 3'd7;
                        step_next = 2'd0;
                        unique case (phase_reg)
                            PH_AK_DEVW:
                            begin
                                phase_next = PH_TX_REG;
                                shift_next = regad_reg;
                            end
                            PH_AK_REG:
                            begin
                                if (rmode_reg)
                                begin
                                    phase_next = PH_RESTART;
                                    bit_next   = bit_reg;
                                end
                                else
                                begin
                                    phase_next = PH_TX_DATA;
                                    shift_next = wbyte_reg;
                                end
                            end
                            PH_AK_DATA:
                            begin
                                phase_next = PH_STOP;
                                bit_next   = bit_reg;
                            end
                            default:
                            begin
                                phase_next = PH_RX;
                                shift_next = 8'd0;
                            end
                        endcase
                    end
                end
                PH_RESTART:
                begin
                    unique case (step_reg)
                        2'd0:
                        begin
                            scl_next = 1'b1; sda_next = 1'b0; step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next = 1'b0; sda_next = 1'b0; step_next = 2'd2;
                        end
                        2'd2:
                        begin
                            scl_next = 1'b0; sda_next = 1'b1; step_next = 2'd3;
                        end
                        default:
                        begin
                            scl_next   = 1'b1; sda_next = 1'b1;
                            phase_next = PH_TX_DEVR;
                            shift_next = {dev_reg, 1'b1};
                            bit_next   = 3'd7;
                            step_next  = 2'd0;
                        end
                    endcase
                end
                PH_RX:
                begin
                    sda_next = 1'b0;
                    if (step_reg == 2'd0)
                    begin
                        // sample the bit driven during the previous high period
                        if (bit_reg != 3'd7 && q_cmd.sda_in)
                        begin
                            shift_next = shift_reg | (8'd1 << ({1'b0, bit_reg} + 4'd1));
                        end
                        scl_next  = 1'b1;
                        step_next = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        step_next = 2'd0;
                        if (bit_reg == 3'd0)
                        begin
                            phase_next = PH_RX_ACK;
                        end
                        else
                        begin
                            bit_next = bit_reg - 3'd1;
                        end
                    end
                end
                PH_RX_ACK:
                begin
                    sda_next = ackdrv;
                    if (step_reg == 2'd0)
                    begin
                        shift_next     = rx_byte;
                        res.data_valid = 1'b1;
                        res.read_data  = rx_byte;
                        res.last_data  = !ackdrv;
                        scl_next       = 1'b1;
                        step_next      = 2'd1;
                    end
                    else
                    begin
                        scl_next  = 1'b0;
                        left_next = left_dec;
                        step_next = 2'd0;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_RX;
                            shift_next = 8'd0;
                            bit_next   = 3'd7;
                        end
                    end
                end
                PH_STOP:
                begin
                    if (step_reg == 2'd0)
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; step_next = 2'd1;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; step_next = 2'd2;
                    end
                    else
                    begin
                        scl_next     = 1'b0; sda_next = 1'b0;
                        res.done_res = 1'b1;
                        res.ack_ok   = ack_reg;
                        phase_next   = PH_IDLE;
                        step_next    = 2'd0;
                        bit_next     = 3'd7;
                    end
                end
                default:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_IDLE;
                    step_next  = 2'd0;
                    bit_next   = 3'd7;
                end
            endcase
        end
        else if ((q_cmd.op == OP_WRITE || q_cmd.op == OP_READ) && phase_reg == PH_IDLE)
        begin
            dev_next   = q_cmd.dev_addr;
            regad_next = q_cmd.reg_addr;
            wbyte_next = q_cmd.write_data;
            rmode_next = (q_cmd.op == OP_READ);
            left_next  = q_cmd.byte_count;
            ack_next   = 1'b1;
            shift_next = 8'd0;
            bit_next   = 3'd7;
            step_next  = 2'd0;
            phase_next = PH_START;
            scl_next   = 1'b0;
            sda_next   = 1'b0;
        end

        res.scl_low  = scl_next;
        res.sda_low  = sda_next;
        res.busy_res = (phase_next != PH_IDLE);

        // Hold the output slot until taken; refill it on a new transfer.
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= 2'd0;
            bit_reg       <= 3'd7;
            shift_reg     <= 8'd0;
            left_reg      <= 8'd0;
            ack_reg       <= 1'b1;
            dev_reg       <= 7'd0;
            regad_reg     <= 8'd0;
            wbyte_reg     <= 8'd0;
            rmode_reg     <= 1'b0;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                step_reg  <= step_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                ack_reg   <= ack_next;
                dev_reg   <= dev_next;
                regad_reg <= regad_next;
                wbyte_reg <= wbyte_next;
                rmode_reg <= rmode_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

[rtl/core/i2c_register_access_master_top.sv]
// Top level: I2C register access master with front, queue and bit engine.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one transfer per item. kind selects
//   a half-bit tick, a register write or a burst read. Commands carry the
//   device address, register, write byte and read count; ticks carry the
//   SDA level sampled by the external half-bit divider.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one result per cmd item,
//   in order: SCL and SDA pull-low drives for the coming half-bit, a received
//   byte with its last flag, and at the stop the AND of all slave ACKs.
// Throughput: one item per cycle sustained while rsp_ready is high; the front
//   pushes into a two-entry queue; the engine steps from its registers once
//   per cycle in which it takes an item. Path: an accepted item is written
//   into a queue entry register, and the engine registers its result in the
//   output register that drives rsp_valid.
// Reset: rst_n clears the queue, drops the output slot and returns the
//   engine to idle with both lines released.
// Stall: while rsp_ready is low the output holds; the queue keeps taking
//   items until it is full, then cmd_ready drops.
`default_nettype none
`include "assert_macros.svh"

module i2c_register_access_master_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire i2cra_pkg::in_item_t cmd,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output i2cra_pkg::out_item_t     rsp
);
    import i2cra_pkg::*;

    q_wr_ctl_t q_wr;
    q_rd_ctl_t q_rd;
    cmd_t      wr_cmd;
    cmd_t      rd_cmd;
    logic      q_full;
    logic      q_pop;

    // Classify and push incoming transfers.
    i2cra_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_cmd     (wr_cmd)
    );

    // Decouple the front from the engine.
    i2cra_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (wr_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd     (q_rd),
        .rd_cmd (rd_cmd)
    );

    // Step the bus engine and register each result.
    i2cra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_cmd     (rd_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // A stop ends the transaction, so the engine reports idle with it.
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, rsp_valid && rsp.done_res, !rsp.busy_res, "done while busy")
    // The ACK summary only comes with the stop.
    `ASSERT_IMPLIES(a_ack_at_done, clk, rst_n, rsp_valid && rsp.ack_ok, rsp.done_res, "ack_ok without done")
    // A received byte belongs to a running burst.
    `ASSERT_IMPLIES(a_data_busy, clk, rst_n, rsp_valid && rsp.data_valid, rsp.busy_res && !rsp.done_res, "byte outside burst")
    // The engine never pops an empty queue.
    `ASSERT_IMPLIES(a_pop_valid, clk, rst_n, q_pop, q_rd.pop, "pop of empty queue")
    // The front never pushes into a full queue.
    `ASSERT_IMPLIES(a_push_room, clk, rst_n, q_wr.push, !q_wr.full, "push into full queue")

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Testbench for the I2C register access master: transfers checked against a cycle model.
module tb_top;
    import i2cra_pkg::*;

    // Kind value that the block treats as a no-op.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // Rough number of input transfers for the whole run.
    localparam int ITEM_BUDGET = 1650;

    // Predict the pin drives, received bytes and stop status of every transfer.
    class pin_drive_scoreboard;
        phase_t     ph;
        logic [1:0] step;
        logic [2:0] bit_idx;
        logic [7:0] shreg;
        logic [7:0] remaining;
        logic       acks_good;
        logic [6:0] dev;
        logic [7:0] regp;
        logic [7:0] wbyte;
        logic       is_read;
        logic       scl_hold;
        logic       sda_hold;
        out_item_t  expected_rsp[$];
        int         mismatches;
        int         checked;
        int         writes_started;
        int         reads_started;
        int         bytes_seen;
        int         stops_seen;

        function new();
            ph = PH_IDLE;
            step = 2'd0;
            bit_idx = 3'd7;
            shreg = 8'h00;
            remaining = 8'h00;
            acks_good = 1'b1;
            dev = 7'h00;
            regp = 8'h00;
            wbyte = 8'h00;
            is_read = 1'b0;
            scl_hold = 1'b0;
            sda_hold = 1'b0;
            mismatches = 0;
            checked = 0;
            writes_started = 0;
            reads_started = 0;
            bytes_seen = 0;
            stops_seen = 0;
        endfunction

        function void hold(logic scl, logic sda);
            scl_hold = scl;
            sda_hold = sda;
        endfunction

        function void load_byte(phase_t next, logic [7:0] value);
            ph = next;
            shreg = value;
            bit_idx = 3'd7;
            step = 2'd0;
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        // The next tick samples a slave ACK.
        function bit ack_due();
            return (ph inside {PH_AK_DEVW, PH_AK_REG, PH_AK_DATA, PH_AK_DEVR}) &&
                   step == 2'd2;
        endfunction

        function out_item_t predict_rsp(in_item_t it);
            out_item_t r;
            logic      bitv;
            logic      ackdrv;
            r = '0;
            if (it.kind == KIND_TICK)
            begin
                case (ph)
                    PH_IDLE:
                        hold(1'b0, 1'b0);
                    PH_START:
                        if (step == 2'd0)
                        begin
                            hold(1'b0, 1'b0);
                            step = 2'd1;
                        end
                        else if (step == 2'd1)
                        begin
                            hold(1'b0, 1'b1);
                            step = 2'd2;
                        end
                        else
                        begin
                            hold(1'b1, 1'b1);
                            load_byte(PH_TX_DEVW, {dev, 1'b0});
                        end
                    PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR:
                    begin
                        bitv = shreg[bit_idx];
                        if (step == 2'd0)
                        begin
                            hold(1'b1, ~bitv);
                            step = 2'd1;
                        end
                        else
                        begin
                            hold(1'b0, ~bitv);
                            step = 2'd0;
                            if (bit_idx == 3'd0)
                                ph = phase_t'(ph + 4'd1);
                            else
                                bit_idx = bit_idx - 3'd1;
                        end
                    end
                    PH_AK_DEVW, PH_AK_REG, PH_AK_DATA, PH_AK_DEVR:
                        if (step == 2'd0)
                        begin
                            hold(1'b1, 1'b0);
                            step = 2'd1;
                        end
                        else if (step == 2'd1)
                        begin
                            hold(1'b0, 1'b0);
                            step = 2'd2;
                        end
                        else
                        begin
                            hold(1'b1, 1'b0);
                            // A NACK only clears the summary, the transaction goes on.
                            if (it.sda_in)
                                acks_good = 1'b0;
                            case (ph)
                                PH_AK_DEVW:
                                    load_byte(PH_TX_REG, regp);
                                PH_AK_REG:
                                    if (is_read)
                                    begin
                                        ph = PH_RESTART;
                                        step = 2'd0;
                                    end
                                    else
                                        load_byte(PH_TX_DATA, wbyte);
                                PH_AK_DATA:
                                begin
                                    ph = PH_STOP;
                                    step = 2'd0;
                                end
                                default:
                                    load_byte(PH_RX, 8'h00);
                            endcase
                        end
                    PH_RESTART:
                        if (step == 2'd0)
                        begin
                            hold(1'b1, 1'b0);
                            step = 2'd1;
                        end
                        else if (step == 2'd1)
                        begin
                            hold(1'b0, 1'b0);
                            step = 2'd2;
                        end
                        else if (step == 2'd2)
                        begin
                            hold(1'b0, 1'b1);
                            step = 2'd3;
                        end
                        else
                        begin
                            hold(1'b1, 1'b1);
                            load_byte(PH_TX_DEVR, {dev, 1'b1});
                        end
                    PH_RX:
                        if (step == 2'd0)
                        begin
                            // The sample belongs to the bit clocked in the period before.
                            if (bit_idx < 3'd7 && it.sda_in)
                                shreg[bit_idx + 1] = 1'b1;
                            hold(1'b1, 1'b0);
                            step = 2'd1;
                        end
                        else
                        begin
                            hold(1'b0, 1'b0);
                            step = 2'd0;
                            if (bit_idx == 3'd0)
                                ph = PH_RX_ACK;
                            else
                                bit_idx = bit_idx - 3'd1;
                        end
                    PH_RX_ACK:
                    begin
                        ackdrv = remaining > 8'd1;
                        if (step == 2'd0)
                        begin
                            if (it.sda_in)
                                shreg[0] = 1'b1;
                            r.data_valid = 1'b1;
                            r.read_data = shreg;
                            r.last_data = remaining <= 8'd1;
                            bytes_seen++;
                            hold(1'b1, ackdrv);
                            step = 2'd1;
                        end
                        else
                        begin
                            hold(1'b0, ackdrv);
                            if (remaining > 8'd0)
                                remaining = remaining - 8'd1;
                            if (remaining == 8'd0)
                            begin
                                ph = PH_STOP;
                                step = 2'd0;
                            end
                            else
                                load_byte(PH_RX, 8'h00);
                        end
                    end
                    PH_STOP:
                        if (step == 2'd0)
                        begin
                            hold(1'b1, 1'b1);
                            step = 2'd1;
                        end
                        else if (step == 2'd1)
                        begin
                            hold(1'b0, 1'b1);
                            step = 2'd2;
                        end
                        else
                        begin
                            hold(1'b0, 1'b0);
                            r.done_res = 1'b1;
                            r.ack_ok = acks_good;
                            stops_seen++;
                            ph = PH_IDLE;
                            step = 2'd0;
                            bit_idx = 3'd7;
                        end
                    default:
                    begin
                        hold(1'b0, 1'b0);
                        ph = PH_IDLE;
                        step = 2'd0;
                        bit_idx = 3'd7;
                    end
                endcase
            end
            else if ((it.kind == KIND_WRITE || it.kind == KIND_READ) && ph == PH_IDLE)
            begin
                dev = it.dev_addr;
                regp = it.reg_addr;
                wbyte = it.write_data;
                is_read = it.kind == KIND_READ;
                remaining = 8'd0;
                if (is_read)
                begin
                    remaining = (it.read_count == 8'd0) ? 8'd1 : it.read_count;
                    reads_started++;
                end
                else
                    writes_started++;
                acks_good = 1'b1;
                shreg = 8'h00;
                bit_idx = 3'd7;
                step = 2'd0;
                ph = PH_START;
                hold(1'b0, 1'b0);
            end
            r.scl_low = scl_hold;
            r.sda_low = sda_hold;
            r.busy_res = ph != PH_IDLE;
            return r;
        endfunction

        function void note_cmd(in_item_t it);
            expected_rsp.push_back(predict_rsp(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_rsp(out_item_t got);
            out_item_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("result %h arrived with nothing expected", got);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            checked++;
            compare_field("scl_low", 8'(want.scl_low), 8'(got.scl_low));
            compare_field("sda_low", 8'(want.sda_low), 8'(got.sda_low));
            compare_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("last_data", 8'(want.last_data), 8'(got.last_data));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("ack_ok", 8'(want.ack_ok), 8'(got.ack_ok));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    in_item_t  cmd = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp;

    pin_drive_scoreboard sb;

    // Sender burst bookkeeping and the count of all transfers sent.
    int burst_left = 0;
    int sent_items = 0;

    i2c_register_access_master_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Fill every field at random; callers overwrite what matters.
    function automatic in_item_t random_item(logic [1:0] kind);
        in_item_t it;
        it.kind       = kind;
        it.dev_addr   = 7'($urandom_range(127));
        it.reg_addr   = 8'($urandom_range(255));
        it.write_data = 8'($urandom_range(255));
        it.read_count = 8'($urandom_range(255));
        it.sda_in     = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t make_cmd(logic [1:0] kind, logic [6:0] dev_addr,
                                          logic [7:0] reg_addr, logic [7:0] write_data,
                                          logic [7:0] read_count);
        in_item_t it;
        it = random_item(kind);
        it.dev_addr   = dev_addr;
        it.reg_addr   = reg_addr;
        it.write_data = write_data;
        it.read_count = read_count;
        return it;
    endfunction

    // Offer one transfer and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; now and then run a long burst with no gaps.
    task automatic offer(input in_item_t it);
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(9) == 0) ? 300 : $urandom_range(1, 40);
        end
        burst_left--;
        cmd <= it;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_ready !== 1'b1);
        sent_items++;
        sb.note_cmd(it);
    endtask

    // Send one tick; at an ACK sample the slave answers NACK with the given odds.
    task automatic send_tick(input int nack_pct);
        in_item_t it;
        it = random_item(KIND_TICK);
        if (sb.ack_due())
            it.sda_in = $urandom_range(99) < nack_pct;
        offer(it);
    endtask

    // Start one transaction from idle and tick it through to its stop,
    // poking in ignored commands and no-ops while it runs.
    task automatic run_transaction(input in_item_t command, input int nack_pct,
                                   input int poke_pct);
        offer(command);
        while (sb.busy())
        begin
            if ($urandom_range(99) < poke_pct)
                offer(random_item(2'($urandom_range(1, 3))));
            else
                send_tick(nack_pct);
        end
    endtask

    // Receiver: check every result and stall on a pattern whose mode is redrawn
    // at random. Once, hold ready low for a long stretch so that
    // the queue fills and the block stalls its command side.
    initial
    begin
        int  hold_left;
        int  seen;
        int  mode;
        int  mode_left;
        int  cyc;
        bit  long_hold_done;
        hold_left = 0;
        seen = 0;
        mode = 0;
        mode_left = 0;
        cyc = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rsp_valid === 1'b1 && rsp_ready)
            begin
                sb.check_rsp(rsp);
                seen++;
            end
            if (seen >= 400 && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left = 300;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= $urandom_range(3) != 0;
                    2: rsp_ready <= cyc % 4 != 0;
                    default: rsp_ready <= $urandom_range(9) < 3;
                endcase
            end
        end
    end

    // Stimulus, drain and verdict.
    initial
    begin
        in_item_t c;
        int       pick;
        int       nack_pct;
        int       spread;
        int       room;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Ticks and a no-op while idle.
        c = random_item(KIND_TICK);
        c.sda_in = 1'b0;
        offer(c);
        c.sda_in = 1'b1;
        offer(c);
        offer(random_item(KIND_SPARE));

        // Writes with field extremes: all acked, then all refused.
        run_transaction(make_cmd(KIND_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00), 0, 5);
        run_transaction(make_cmd(KIND_WRITE, 7'h00, 8'h00, 8'hFF, 8'hFF), 100, 5);

        // Bursts: zero count acts as one byte, then short ones, then a longer one.
        run_transaction(make_cmd(KIND_READ, 7'h55, 8'hAA, 8'h5A, 8'h00), 0, 0);
        run_transaction(make_cmd(KIND_READ, 7'h2A, 8'h55, 8'hA5, 8'h01), 50, 3);
        run_transaction(make_cmd(KIND_READ, 7'h7F, 8'hFF, 8'hFF, 8'h02), 0, 3);
        run_transaction(make_cmd(KIND_READ, 7'h01, 8'h80, 8'h7F, 8'h10), 10, 1);

        // Random transactions, with some idle noise between them.
        while (sent_items < ITEM_BUDGET)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                offer(random_item(pick < 3 ? KIND_TICK : KIND_SPARE));
            else
            begin
                c = random_item(pick < 50 ? KIND_WRITE : KIND_READ);
                spread = $urandom_range(99);
                if (spread < 80)
                    c.read_count = 8'($urandom_range(0, 4));
                else if (spread < 97)
                    c.read_count = 8'($urandom_range(5, 20));
                else
                    c.read_count = 8'($urandom_range(21, 40));
                // Shrink a burst that would run well past the budget.
                room = (ITEM_BUDGET - sent_items - 80) / 18;
                if (int'(c.read_count) > room)
                    c.read_count = (room > 1) ? 8'(room) : 8'd1;
                case ($urandom_range(5))
                    3: nack_pct = 5;
                    4: nack_pct = 50;
                    5: nack_pct = 100;
                    default: nack_pct = 0;
                endcase
                run_transaction(c, nack_pct, $urandom_range(0, 8));
            end
        end
        cmd_valid <= 1'b0;

        // Drain, then keep the clock running so that stray results can show.
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d register writes, %0d burst reads, %0d bytes read, %0d stops",
                 sb.writes_started, sb.reads_started, sb.bytes_seen, sb.stops_seen);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
